[rtl/bdvm_pkg.sv]
// Shared types and codes for the dirty/valid block map.
package bdvm_pkg;

  // Geometry of the map
  localparam int BLOCK_BYTES = 4096;
  localparam int MAX_BLOCKS  = 4096;
  localparam int MAX_RUN     = 256;

  typedef enum logic [2:0] {
    FN_WRITE   = 3'd0,
    FN_READ    = 3'd1,
    FN_INVAL   = 3'd2,
    FN_TAKE    = 3'd3,
    FN_REDIRTY = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_REJECT  = 3'd1,
    ST_MISS    = 3'd2,
    ST_NODIRTY = 3'd3,
    ST_OVER    = 3'd4
  } status_t;

  localparam logic [1:0] REG_BLOCKS = 2'd0;
  localparam logic [1:0] REG_VOLUME = 2'd1;
  localparam logic [1:0] REG_FLUSH  = 2'd2;

endpackage

[rtl/bdvm_urgency.sv]
// Flush-urgency class from the dirty count and the blocks in use.
module bdvm_urgency
  import bdvm_pkg::*;
#(
  parameter int CW = 13
) (
  input  logic [CW-1:0] dirty,
  input  logic [CW-1:0] used,
  output logic [2:0]    urgency
);

  logic [CW+3:0] d4, d3n, d2, d10, n;

  assign n   = (CW+4)'(used);
  assign d4  = (CW+4)'(dirty) << 2;
  assign d2  = (CW+4)'(dirty) << 1;
  assign d10 = ((CW+4)'(dirty) << 3) + ((CW+4)'(dirty) << 1);
  assign d3n = (n << 1) + n;

  // Pick the highest class whose ratio compare holds
  always_comb begin
    if (used == '0)     urgency = 3'd0;
    else if (d4 > d3n)  urgency = 3'd4;
    else if (d2 > n)    urgency = 3'd3;
    else if (d4 > n)    urgency = 3'd2;
    else if (d10 > n)   urgency = 3'd1;
    else                urgency = 3'd0;
  end

endmodule

[rtl/block_dirty_valid_map.sv]
// Top level of the dirty/valid block map.
// Usage: pulse start with func, byte_offset and byte_length while busy is low.
// busy rises on the next cycle; when the operation finishes, done strobes for
// one cycle with all result fields, and busy falls with it, so the next beat
// can be taken in the done cycle. The receiver cannot stall; results must be
// captured on the done cycle.
// Valid and dirty bits live in two one-bit-wide memories with registered reads,
// and each block touched passes through a read state (S_RD) and a check/write-back
// state (S_CHK); a miss stops at the first invalid block, and a rejected command
// goes straight to S_DONE. A take-run scans in S_SRCH and S_RUN, drops blocks
// past the volume in S_CLIP, then clears the run in S_CLR.
// Reset clears the counters at once and then sweeps both memories, one entry
// a cycle, with busy high.
// Any write of blocks_in_use through the APB port starts a sweep that clears
// blocks at and above the new count, one a cycle, with busy high.
module block_dirty_valid_map
  import bdvm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func,
  input  logic [31:0] byte_offset,
  input  logic [31:0] byte_length,
  output logic        done,
  output logic [2:0]  status,
  output logic [11:0] run_start_block,
  output logic [8:0]  run_blocks,
  output logic [12:0] resume_block,
  output logic [31:0] hits_total,
  output logic [31:0] misses_total,
  output logic [12:0] dirty_blocks,
  output logic [2:0]  urgency,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int AW  = $clog2(MAX_BLOCKS);
  localparam int CW  = AW + 1;
  localparam int BSH = $clog2(BLOCK_BYTES);
  localparam int RW  = $clog2(MAX_RUN + 1);

  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_RD    = 9'b000000100,
    S_CHK   = 9'b000001000,
    S_SRCH  = 9'b000010000,
    S_RUN   = 9'b000100000,
    S_CLIP  = 9'b001000000,
    S_CLR   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state;

  // Config registers
  logic [12:0] blocks_in_use;
  logic [47:0] volume_bytes;
  logic [24:0] flush_limit_bytes;
  logic [CW-1:0] used;
  assign used = (blocks_in_use > 13'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(blocks_in_use);

  // Bit memories
  logic vmem [MAX_BLOCKS];
  logic dmem [MAX_BLOCKS];
  logic v_q, d_q;
  logic          we_v, we_d, wv, wd;
  logic [AW-1:0] waddr, raddr;

  always_ff @(posedge clk) begin
    if (we_v) vmem[waddr] <= wv;
    if (we_d) dmem[waddr] <= wd;
    v_q <= vmem[raddr];
    d_q <= dmem[raddr];
  end

  // Operation registers
  func_t         op;
  logic [CW-1:0] cur, last, bstart;
  logic [RW-1:0] run;
  logic [2:0]    st;
  logic [31:0]   hits, misses;
  logic [CW-1:0] dirty;
  logic          pend;
  logic          cfg_wr;
  logic [63:0]   boff_end;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign busy   = (state != S_IDLE);
  assign raddr  = cur[AW-1:0];

  // Byte range to blocks
  logic [32:0] rng_end;
  logic        rng_ok;
  logic [CW-1:0] rng_first, rng_last;
  logic [32+1:0] ceil_end;
  assign rng_end  = {1'b0, byte_offset} + {1'b0, byte_length};
  assign rng_ok   = (byte_length != '0) &&
                    ({31'b0, rng_end} <= (64'(used) << BSH));
  assign ceil_end = {1'b0, rng_end} + 34'(BLOCK_BYTES - 1);
  assign rng_first = CW'(byte_offset >> BSH);
  assign rng_last  = ((ceil_end >> BSH) > 34'(used)) ? used : CW'(ceil_end >> BSH);
  assign boff_end  = (64'(bstart) << BSH) + (64'(run) << BSH);

  // Write port control
  always_comb begin
    we_v = 1'b0; we_d = 1'b0; wv = 1'b0; wd = 1'b0;
    waddr = cur[AW-1:0];
    unique case (state)
      S_INIT: if (cur < CW'(MAX_BLOCKS)) begin we_v = 1'b1; we_d = 1'b1; end
      S_CHK: begin
        unique case (op)
          FN_WRITE:   begin we_v = 1'b1; we_d = 1'b1; wv = 1'b1; wd = 1'b1; end
          FN_INVAL:   begin we_v = 1'b1; we_d = 1'b1; end
          FN_REDIRTY: begin we_d = 1'b1; wd = 1'b1; end
          default: ;
        endcase
      end
      S_CLR: we_d = 1'b1;
      default: ;
    endcase
  end

  // Track the dirty count: run blocks are known dirty, so each clear step
  // drops it by one; a shrink sweep counts the bit read one step earlier
  logic [CW-1:0] dirty_adj;
  always_comb begin
    dirty_adj = dirty;
    if (state == S_CHK) begin
      if ((op == FN_WRITE || op == FN_REDIRTY) && !d_q) dirty_adj = dirty + 1'b1;
      if (op == FN_INVAL && d_q) dirty_adj = dirty - 1'b1;
    end
    if (state == S_CLR) dirty_adj = dirty - 1'b1;
    if (state == S_INIT && pend && cur > used && d_q) dirty_adj = dirty - 1'b1;
  end

  logic [2:0] urg;
  bdvm_urgency #(.CW(CW)) u_urg (.dirty(dirty), .used(used), .urgency(urg));

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT; cur <= '0; pend <= 1'b0; done <= 1'b0;
      hits <= '0; misses <= '0; dirty <= '0;
      blocks_in_use <= 13'd4096; volume_bytes <= '1; flush_limit_bytes <= 25'd1048576;
    end else begin
      done <= 1'b0;
      dirty <= dirty_adj;
      // Take register writes; a new block count restarts the sweep
      if (cfg_wr && paddr[4:3] == REG_VOLUME) volume_bytes <= pwdata[47:0];
      if (cfg_wr && paddr[4:3] == REG_FLUSH)  flush_limit_bytes <= pwdata[24:0];
      if (cfg_wr && paddr[4:3] == REG_BLOCKS) begin
        blocks_in_use <= pwdata[12:0];
        state <= S_INIT; pend <= 1'b1;
        cur <= (pwdata[12:0] > 13'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(pwdata[12:0]);
      end else begin
        unique case (state)
          // Sweep: on a shrink the bit of cur-1 is read back while cur is cleared
          S_INIT: begin
            if (pend) begin
              if (cur >= CW'(MAX_BLOCKS)) begin state <= S_IDLE; pend <= 1'b0; end
              else cur <= cur + 1'b1;
            end else if (cur == CW'(MAX_BLOCKS - 1)) state <= S_IDLE;
            else cur <= cur + 1'b1;
          end
          S_IDLE: if (start) begin
            op <= func_t'(func); st <= ST_OK;
            run <= '0; bstart <= '0; last <= used;
            if (func == FN_TAKE) begin
              cur <= ((byte_offset >> BSH) > 32'(used)) ? used : CW'(byte_offset >> BSH);
              state <= S_RD;
            end else if (func > FN_REDIRTY) begin
              st <= ST_REJECT; state <= S_DONE;
            end else if (!rng_ok) begin
              st <= ST_REJECT; state <= S_DONE;
            end else begin
              cur <= rng_first; last <= rng_last; state <= S_RD;
            end
          end
          // Issue a read for cur
          S_RD: begin
            if (cur >= last) begin
              if (op == FN_TAKE) begin
                if (run == '0) begin st <= ST_NODIRTY; state <= S_DONE; end
                else state <= S_CLIP;
              end else begin
                if (op == FN_READ) hits <= hits + 1'b1;
                state <= S_DONE;
              end
            end else state <= (op == FN_TAKE) ? ((run == '0) ? S_SRCH : S_RUN) : S_CHK;
          end
          S_CHK: begin
            if (op == FN_READ && !v_q) begin
              misses <= misses + 1'b1; st <= ST_MISS; state <= S_DONE;
            end else begin cur <= cur + 1'b1; state <= S_RD; end
          end
          S_SRCH: begin
            if (d_q) begin bstart <= cur; run <= RW'(1); last <= used; end
            cur <= cur + 1'b1; state <= S_RD;
          end
          S_RUN: begin
            if (d_q && run != RW'(MAX_RUN)) begin
              run <= run + 1'b1; cur <= cur + 1'b1;
              state <= (run + 1'b1 == RW'(MAX_RUN)) ? S_CLIP : S_RD;
            end else state <= S_CLIP;
          end
          // Walk the run back until it ends within the volume, keeping at least one block, then check the flush limit
          S_CLIP: begin
            if (run > RW'(1) && boff_end > 64'(volume_bytes)) run <= run - 1'b1;
            else if ((64'(run) << BSH) > 64'(flush_limit_bytes)) begin
              st <= ST_OVER; state <= S_DONE;
            end else begin cur <= bstart; state <= S_CLR; end
          end
          S_CLR: begin
            if (cur + 1'b1 >= bstart + CW'(run)) state <= S_DONE;
            cur <= cur + 1'b1;
          end
          S_DONE: begin done <= 1'b1; state <= S_IDLE; end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  // Drive result fields from the held operation registers
  always_comb begin
    status          = st;
    run_start_block = (op == FN_TAKE && st != ST_NODIRTY) ? 12'(bstart) : '0;
    run_blocks      = (op == FN_TAKE && st != ST_NODIRTY) ? 9'(run) : '0;
    resume_block    = (op != FN_TAKE || st == ST_REJECT) ? '0 :
                      (st == ST_NODIRTY) ? 13'(used) : 13'(bstart + CW'(run));
    hits_total      = hits;
    misses_total    = misses;
    dirty_blocks    = 13'(dirty);
    urgency         = urg;
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_BLOCKS: prdata = 64'(blocks_in_use);
      REG_VOLUME: prdata = 64'(volume_bytes);
      REG_FLUSH:  prdata = 64'(flush_limit_bytes);
      default:    prdata = '0;
    endcase
  end

  a_done_one: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held two cycles");
  a_dirty_bound: assert property (@(posedge clk) disable iff (rst) dirty <= CW'(MAX_BLOCKS))
    else $error("dirty count out of range");
  a_run_bound: assert property (@(posedge clk) disable iff (rst) run <= RW'(MAX_RUN))
    else $error("run too long");

endmodule

[verif/block_dirty_valid_map_chk.sv]
// Checker for the dirty/valid block map: predicts each result and compares it.
module block_dirty_valid_map_chk
  import bdvm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  func,
  input  logic [31:0] byte_offset,
  input  logic [31:0] byte_length,
  input  logic        done,
  input  logic [2:0]  status,
  input  logic [11:0] run_start_block,
  input  logic [8:0]  run_blocks,
  input  logic [12:0] resume_block,
  input  logic [31:0] hits_total,
  input  logic [31:0] misses_total,
  input  logic [12:0] dirty_blocks,
  input  logic [2:0]  urgency,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending,
  output int          beats_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned BLK_BYTES = 4096;
  localparam int              MAP_DEPTH = 4096;
  localparam longint unsigned RUN_MAX   = 256;

  typedef struct {
    status_t     st;
    logic [11:0] rstart;
    logic [8:0]  rblocks;
    logic [12:0] resume;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [12:0] dirty;
    logic [2:0]  urg;
  } map_result_t;

  map_result_t result_fifo[$];

  // Shadow of the map and its registers
  bit              shadow_valid[MAP_DEPTH];
  bit              shadow_dirty[MAP_DEPTH];
  logic [31:0]     hit_cnt;
  logic [31:0]     miss_cnt;
  int unsigned     dirty_cnt;
  logic [12:0]     cfg_blocks;
  logic [47:0]     cfg_volume;
  logic [24:0]     cfg_flush;

  function automatic longint unsigned blocks_used();
    return (cfg_blocks > MAP_DEPTH) ? MAP_DEPTH : longint'(cfg_blocks);
  endfunction

  function automatic void mark_dirty(longint unsigned b, bit v);
    if (shadow_dirty[b] != v) begin
      if (v) dirty_cnt++;
      else dirty_cnt--;
      shadow_dirty[b] = v;
    end
  endfunction

  function automatic logic [2:0] flush_class();
    longint unsigned d;
    longint unsigned n;
    d = dirty_cnt;
    n = blocks_used();
    if (n == 0) return 3'd0;
    if (4 * d > 3 * n) return 3'd4;
    if (2 * d > n) return 3'd3;
    if (4 * d > n) return 3'd2;
    if (10 * d > n) return 3'd1;
    return 3'd0;
  endfunction

  // Apply one operation to the shadow map and return its result
  function automatic map_result_t apply_op(logic [2:0] f, logic [31:0] o, logic [31:0] l);
    map_result_t r;
    longint unsigned n, off, len, stop, first, last, b, run, boff;
    bit whole_range;
    n = blocks_used();
    off = o;
    len = l;
    r.st = ST_OK;
    r.rstart = '0;
    r.rblocks = '0;
    r.resume = '0;
    if (f == FN_WRITE || f == FN_READ || f == FN_INVAL || f == FN_REDIRTY) begin
      stop = off + len;
      if (len == 0 || stop > n * BLK_BYTES) begin
        r.st = ST_REJECT;
      end else begin
        first = off / BLK_BYTES;
        last = (stop + BLK_BYTES - 1) / BLK_BYTES;
        if (last > n) last = n;
        case (f)
          FN_WRITE: begin
            for (b = first; b < last; b++) begin
              shadow_valid[b] = 1'b1;
              mark_dirty(b, 1'b1);
            end
          end
          FN_READ: begin
            whole_range = 1'b1;
            for (b = first; b < last; b++) if (!shadow_valid[b]) whole_range = 1'b0;
            if (whole_range) begin
              hit_cnt++;
            end else begin
              miss_cnt++;
              r.st = ST_MISS;
            end
          end
          FN_INVAL: begin
            for (b = first; b < last; b++) begin
              shadow_valid[b] = 1'b0;
              mark_dirty(b, 1'b0);
            end
          end
          default: begin
            for (b = first; b < last; b++) mark_dirty(b, 1'b1);
          end
        endcase
      end
    end else if (f == FN_TAKE) begin
      b = off / BLK_BYTES;
      while (b < n && !shadow_dirty[b]) b++;
      if (b >= n) begin
        r.st = ST_NODIRTY;
        r.resume = n[12:0];
      end else begin
        run = 1;
        boff = b * BLK_BYTES;
        while (b + run < n && run < RUN_MAX && shadow_dirty[b + run]) run++;
        // shorten the run to end inside the volume, keep at least one block
        while (run > 1 && boff + run * BLK_BYTES > cfg_volume) run--;
        r.rstart = b[11:0];
        r.rblocks = run[8:0];
        r.resume = 13'(b + run);
        if (run * BLK_BYTES > cfg_flush) begin
          r.st = ST_OVER;
        end else begin
          for (longint unsigned i = b; i < b + run; i++) mark_dirty(i, 1'b0);
        end
      end
    end else begin
      r.st = ST_REJECT;
    end
    r.hits = hit_cnt;
    r.misses = miss_cnt;
    r.dirty = dirty_cnt[12:0];
    r.urg = flush_class();
    return r;
  endfunction

  function automatic void check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  assign pending = result_fifo.size();

  initial begin
    fail_count = 0;
    beats_checked = 0;
  end

  always @(posedge clk) begin
    map_result_t e;
    if (rst) begin
      foreach (shadow_valid[i]) begin
        shadow_valid[i] = 1'b0;
        shadow_dirty[i] = 1'b0;
      end
      hit_cnt = '0;
      miss_cnt = '0;
      dirty_cnt = 0;
      cfg_blocks = 13'd4096;
      cfg_volume = 48'hFFFF_FFFF_FFFF;
      cfg_flush = 25'd1048576;
      result_fifo.delete();
    end else begin
      // compare a result beat with the oldest expectation
      if (done) begin
        beats_checked++;
        if (result_fifo.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          e = result_fifo.pop_front();
          check_field("status", e.st, status);
          check_field("run_start_block", e.rstart, run_start_block);
          check_field("run_blocks", e.rblocks, run_blocks);
          check_field("resume_block", e.resume, resume_block);
          check_field("hits_total", e.hits, hits_total);
          check_field("misses_total", e.misses, misses_total);
          check_field("dirty_blocks", e.dirty, dirty_blocks);
          check_field("urgency", e.urg, urgency);
        end
      end
      // predict on an accepted command beat
      if (start && !busy) result_fifo.push_back(apply_op(func, byte_offset, byte_length));
      // track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:3])
          REG_BLOCKS: begin
            cfg_blocks = pwdata[12:0];
            for (longint unsigned b = blocks_used(); b < MAP_DEPTH; b++) begin
              shadow_valid[b] = 1'b0;
              mark_dirty(b, 1'b0);
            end
          end
          REG_VOLUME: cfg_volume = pwdata[47:0];
          REG_FLUSH: cfg_flush = pwdata[24:0];
          default: ;
        endcase
      end
    end
  end
endmodule

[verif/block_dirty_valid_map_tb.sv]
// Testbench top for the dirty/valid block map: stimulus, register setup and verdict.
module block_dirty_valid_map_tb;
  import bdvm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned BLK   = 4096;
  localparam int              LIMIT = 4000000;
  localparam logic [2:0]      FN_SPARE_LO  = 3'd5;
  localparam logic [2:0]      FN_SPARE_MID = 3'd6;
  localparam logic [2:0]      FN_SPARE_HI  = 3'd7;

  logic        clk, rst, start, busy, done, psel, penable, pwrite, pready;
  logic [2:0]  func, status, urgency;
  logic [31:0] byte_offset, byte_length, hits_total, misses_total;
  logic [11:0] run_start_block;
  logic [8:0]  run_blocks;
  logic [12:0] resume_block, dirty_blocks;
  logic [4:0]  paddr;
  logic [63:0] pwdata, prdata;
  int          fail_count, pending, beats_checked;
  int          cycles, items_sent, cfg_writes, idle_pct;
  longint unsigned cur_blocks;

  block_dirty_valid_map i_dut (.*);

  block_dirty_valid_map_chk i_chk (.*);

  // Clock and cycle limit
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Send one command beat, hold start until it is taken
  task automatic send_op(logic [2:0] f, logic [31:0] o, logic [31:0] l);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    func = f;
    byte_offset = o;
    byte_length = l;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    items_sent++;
  endtask

  // Drain and wait out any sweep, then write one register over APB
  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    @(negedge clk);
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 3'b000};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (idx == REG_BLOCKS) cur_blocks = (val[12:0] > 4096) ? 4096 : val[12:0];
    cfg_writes++;
  endtask

  // One random command, mostly well formed inside the capacity
  task automatic random_op();
    logic [2:0] f;
    longint unsigned cap, o, l, span;
    int pick;
    cap = cur_blocks * BLK;
    pick = $urandom_range(0, 99);
    if (pick < 30) f = FN_WRITE;
    else if (pick < 50) f = FN_READ;
    else if (pick < 62) f = FN_INVAL;
    else if (pick < 80) f = FN_TAKE;
    else if (pick < 95) f = FN_REDIRTY;
    else f = 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
    if ($urandom_range(0, 99) < 12 || cap == 0) begin
      o = $urandom();
      l = ($urandom_range(0, 3) == 0) ? 0 : $urandom();
    end else begin
      o = $urandom_range(0, int'(cap - 1));
      span = cap - o;
      if (span > 24 * BLK) span = 24 * BLK;
      l = $urandom_range(1, int'(span));
      if ($urandom_range(0, 19) == 0) l = l + BLK;
    end
    send_op(f, o[31:0], l[31:0]);
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if (items_sent < 540) idle_pct = 18;
      else if (items_sent < 1060) idle_pct = 46;
      else idle_pct = 0;
      random_op();
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    func = FN_WRITE;
    byte_offset = '0;
    byte_length = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    items_sent = 0;
    cfg_writes = 0;
    idle_pct = 0;
    cur_blocks = 4096;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // Directed: hits, misses, rejects, runs, clips and limits
    send_op(FN_WRITE, 32'd0, 32'd1);
    send_op(FN_READ, 32'd0, 32'd1);
    send_op(FN_READ, 32'd0, 32'd8192);
    send_op(FN_WRITE, 32'd0, 32'd0);
    send_op(FN_WRITE, 32'd4095, 32'd2);
    send_op(FN_WRITE, 32'd16777215, 32'd1);
    send_op(FN_WRITE, 32'd16777215, 32'd2);
    send_op(FN_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(FN_TAKE, 32'd0, 32'd0);
    send_op(FN_REDIRTY, 32'd0, 32'd12288);
    send_op(FN_INVAL, 32'd4096, 32'd4096);
    send_op(FN_TAKE, 32'hFFFF_FFFF, 32'd0);
    send_op(FN_SPARE_LO, 32'd0, 32'd1);
    send_op(FN_SPARE_MID, 32'hFFFF_FFFF, 32'd0);
    send_op(FN_SPARE_HI, 32'd0, 32'hFFFF_FFFF);
    send_op(FN_INVAL, 32'd0, 32'd16777216);
    send_op(FN_TAKE, 32'd0, 32'd0);
    send_op(FN_WRITE, 32'd0, 32'd1228800);
    send_op(FN_TAKE, 32'd0, 32'd0);
    write_reg(REG_FLUSH, 64'd0);
    send_op(FN_TAKE, 32'd0, 32'd0);
    write_reg(REG_FLUSH, 64'd16777216);
    write_reg(REG_VOLUME, 64'd8193);
    send_op(FN_TAKE, 32'd0, 32'd0);
    write_reg(REG_VOLUME, 64'd0);
    send_op(FN_TAKE, 32'd4096, 32'd0);
    write_reg(REG_BLOCKS, 64'd0);
    send_op(FN_WRITE, 32'd0, 32'd1);
    send_op(FN_TAKE, 32'd0, 32'd0);

    // Random phases across several register settings
    write_reg(REG_BLOCKS, 64'd64);
    write_reg(REG_VOLUME, 64'hFFFF_FFFF_FFFF);
    write_reg(REG_FLUSH, 64'd1048576);
    random_phase(560);
    // hold off until every result is back
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    write_reg(REG_BLOCKS, 64'd4096);
    write_reg(REG_VOLUME, 64'd81920 + 64'd123);
    write_reg(REG_FLUSH, 64'd32768);
    random_phase(110);
    write_reg(REG_BLOCKS, 64'd300);
    write_reg(REG_VOLUME, 64'd1 << 40);
    write_reg(REG_FLUSH, 64'd16777216);
    random_phase(380);
    write_reg(REG_BLOCKS, 64'd1);
    write_reg(REG_FLUSH, 64'd0);
    random_phase(100);
    write_reg(REG_BLOCKS, 64'd8191);
    write_reg(REG_VOLUME, 64'hFFFF_FFFF_FFFF);
    write_reg(REG_FLUSH, 64'd1048576);
    random_phase(110);
    write_reg(REG_BLOCKS, 64'd0);
    random_phase(60);
    write_reg(REG_BLOCKS, 64'd40);
    write_reg(REG_VOLUME, 64'd0);
    random_phase(200);

    // Drain and settle
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("Ran %0d command beats over %0d register writes, %0d results checked.",
             items_sent, cfg_writes, beats_checked);
    $display("Covered writes, reads, invalidates, redirty, take-run clips and limits.");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

[block_dirty_valid_map.f]
rtl/bdvm_pkg.sv
rtl/bdvm_urgency.sv
rtl/block_dirty_valid_map.sv
verif/block_dirty_valid_map_chk.sv
verif/block_dirty_valid_map_tb.sv
